FILE: hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: register
// indexes, ranging phase codes, distance scaling and controller encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_LOW = 2'd0,
        CFG_TRIGGER = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_GAP     = 2'd3
    } cfg_idx_t;

    localparam int PRE_LOW_W = 10;
    localparam int TRIG_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int GAP_W     = 20;

    localparam logic [PRE_LOW_W-1:0] PRE_LOW_RESET = 10'd2;
    localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30000;
    localparam logic [GAP_W-1:0]     GAP_RESET     = 20'd50000;

    // ranging phases
    typedef enum logic [2:0] {
        PH_PRE_LOW   = 3'd0,
        PH_TRIGGER   = 3'd1,
        PH_WAIT_RISE = 3'd2,
        PH_MEASURE   = 3'd3,
        PH_GAP       = 3'd4
    } ranging_phase_t;

    // distance arithmetic, unsigned fixed point with DIST_FRAC_BITS fraction
    localparam int DIST_FRAC_BITS = 6;
    localparam int DIST_W         = 16;
    localparam int ECHO_W         = 16;
    localparam int DIST_SCALE     = 343 << DIST_FRAC_BITS;
    localparam int DIST_ROUND     = 10000;
    localparam int DIST_DIVISOR   = 20000;
    localparam int SMOOTH_DIVISOR = 5;
    localparam int SMOOTH_RESET   = 50 << DIST_FRAC_BITS;
    localparam int SMOOTH_SUM_W   = DIST_W + 3;

    // echo_count * scale + round
    localparam int PROD_W = ECHO_W + $clog2(DIST_SCALE);

    // constant division as (x * recip) >> shift, recip rounded up, with
    // shift = width of x + clog2(divisor) so the quotient is exact for every x
    localparam int DIST_SHIFT     = PROD_W + $clog2(DIST_DIVISOR);
    localparam int DIST_RECIP_W   = DIST_SHIFT - $clog2(DIST_DIVISOR) + 1;
    localparam logic [63:0] DIST_RECIP =
        ((64'd1 << DIST_SHIFT) + 64'(DIST_DIVISOR) - 64'd1) / 64'(DIST_DIVISOR);
    localparam int SMOOTH_SHIFT   = SMOOTH_SUM_W + $clog2(SMOOTH_DIVISOR);
    localparam int SMOOTH_RECIP_W = SMOOTH_SHIFT - $clog2(SMOOTH_DIVISOR) + 1;
    localparam logic [63:0] SMOOTH_RECIP =
        ((64'd1 << SMOOTH_SHIFT) + 64'(SMOOTH_DIVISOR) - 64'd1) / 64'(SMOOTH_DIVISOR);

    // controller
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_RAW,
        ST_SAVE_RAW,
        ST_DIV_SMOOTH,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic load_raw;
        logic div_raw;
        logic save_raw;
        logic div_smooth;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic completes;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels of the ranger: the per-tick echo input and the
// per-tick result.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_tick_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface uer_result_if;
    import uer_pkg::*;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic [DIST_W-1:0] filtered_distance;
    logic [DIST_W-1:0] raw_distance;
    logic              measure_done;
    logic              timed_out;

    modport source (output valid, output trigger_level, output filtered_distance,
                    output raw_distance, output measure_done, output timed_out,
                    input ready);
    modport sink   (input valid, input trigger_level, input filtered_distance,
                    input raw_distance, input measure_done, input timed_out,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Handshake and sequencing controller: accepts ticks, runs the distance
// and smoothing divisions for a finished echo, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire uer_pkg::dp_status_t status,
    output uer_pkg::dp_cmd_t         cmd
);
    import uer_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.completes)
                        state_next = ST_MUL;
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.load_raw = 1'b1;
                state_next   = ST_DIV_RAW;
            end
            ST_DIV_RAW:
            begin
                cmd.div_raw = 1'b1;
                state_next  = ST_SAVE_RAW;
            end
            ST_SAVE_RAW:
            begin
                cmd.save_raw = 1'b1;
                state_next   = ST_DIV_SMOOTH;
            end
            ST_DIV_SMOOTH:
            begin
                cmd.div_smooth = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp
// Ranger datapath: configuration registers, phase sequencing counters,
// distance multiplier, reciprocal-multiply constant dividers and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dp #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire uer_pkg::dp_cmd_t                cmd,
    output uer_pkg::dp_status_t                  status,
    input  wire logic                            echo_level,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 trigger_level,
    output logic [uer_pkg::DIST_W-1:0]           filtered_distance,
    output logic [uer_pkg::DIST_W-1:0]           raw_distance,
    output logic                                 measure_done,
    output logic                                 timed_out
);
    import uer_pkg::*;

    // compare width wide enough for the count and the gap limit
    localparam int CW = (COUNT_BITS > GAP_W) ? COUNT_BITS : GAP_W;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam int RAW_MUL_W    = PROD_W + DIST_RECIP_W;
    localparam int RAW_Q_W      = RAW_MUL_W - DIST_SHIFT;
    localparam int SMOOTH_MUL_W = SMOOTH_SUM_W + SMOOTH_RECIP_W;

    logic [PRE_LOW_W-1:0]  pre_low_reg;
    logic [TRIG_W-1:0]     trig_ticks_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [GAP_W-1:0]      gap_reg;

    ranging_phase_t        phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [ECHO_W-1:0]     echo_count_reg, echo_count_next;
    logic [DIST_W-1:0]     smoothed_reg;
    logic [DIST_W-1:0]     last_raw_reg;

    logic [PROD_W-1:0]       prod_reg;
    logic [RAW_Q_W-1:0]      raw_q_reg;
    logic [SMOOTH_SUM_W-1:0] sum_reg;
    logic [DIST_W-1:0]       smooth_q_reg;

    logic                  trig_out_reg;
    logic [DIST_W-1:0]     filt_out_reg;
    logic [DIST_W-1:0]     raw_out_reg;
    logic                  done_out_reg;
    logic                  tout_out_reg;

    logic [COUNT_BITS-1:0] count_inc;
    logic [CW-1:0]         inc_ext;
    logic [CW-1:0]         gap_lim;
    logic [TRIG_W-1:0]     trig_lim;
    logic                  tick_trig;
    logic                  tick_tout;
    logic                  tick_completes;
    logic                  go;
    ranging_phase_t        target;
    ranging_phase_t        resolved;

    logic [PROD_W-1:0]       product;
    logic [RAW_MUL_W-1:0]    raw_mul;
    logic [SMOOTH_MUL_W-1:0] smooth_mul;
    logic [DIST_W-1:0]       raw_sat;
    logic [SMOOTH_SUM_W-1:0] smooth_sum;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_low_reg    <= PRE_LOW_RESET;
            trig_ticks_reg <= TRIG_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            gap_reg        <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRE_LOW: pre_low_reg    <= cfg_data[PRE_LOW_W-1:0];
                CFG_TRIGGER: trig_ticks_reg <= cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT: timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                CFG_GAP:     gap_reg        <= cfg_data[GAP_W-1:0];
                default:     pre_low_reg    <= pre_low_reg;
            endcase
        end
    end

    // ---------------- per-tick phase sequencing ----------------
    assign count_inc = (count_reg == CMAX) ? count_reg : count_reg + COUNT_BITS'(1);
    assign inc_ext   = CW'(count_inc);
    assign gap_lim   = (CW'(gap_reg) > CW'(CMAX)) ? CW'(CMAX) : CW'(gap_reg);
    assign trig_lim  = (trig_ticks_reg == '0) ? TRIG_W'(1) : trig_ticks_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        echo_count_next = echo_count_reg;
        tick_trig       = 1'b0;
        tick_tout       = 1'b0;
        tick_completes  = 1'b0;
        go              = 1'b0;
        target          = PH_PRE_LOW;
        resolved        = PH_PRE_LOW;
        unique case (phase_reg)
            PH_PRE_LOW:
            begin
                count_next = count_inc;
                if (inc_ext >= CW'(pre_low_reg))
                begin
                    go     = 1'b1;
                    target = PH_TRIGGER;
                end
            end
            PH_TRIGGER:
            begin
                tick_trig  = 1'b1;
                count_next = count_inc;
                if (inc_ext >= CW'(trig_lim))
                begin
                    go     = 1'b1;
                    target = PH_WAIT_RISE;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo_level)
                begin
                    echo_count_next = ECHO_W'(1);
                    go              = 1'b1;
                    target          = PH_MEASURE;
                end
                else
                begin
                    count_next = count_inc;
                    if (inc_ext > CW'(timeout_reg) || count_inc == CMAX)
                    begin
                        tick_tout = 1'b1;
                        go        = 1'b1;
                        target    = PH_GAP;
                    end
                end
            end
            PH_MEASURE:
            begin
                if (echo_level)
                begin
                    if (echo_count_reg >= timeout_reg)
                    begin
                        tick_tout = 1'b1;
                        go        = 1'b1;
                        target    = PH_GAP;
                    end
                    else
                    begin
                        echo_count_next = echo_count_reg + ECHO_W'(1);
                    end
                end
                else
                begin
                    tick_completes = 1'b1;
                    go             = 1'b1;
                    target         = PH_GAP;
                end
            end
            PH_GAP:
            begin
                count_next = count_inc;
                if (inc_ext >= gap_lim)
                begin
                    go     = 1'b1;
                    target = PH_PRE_LOW;
                end
            end
            default:
            begin
                go     = 1'b1;
                target = PH_PRE_LOW;
            end
        endcase

        // zero length gap and pre-low phases are skipped
        resolved = target;
        if (resolved == PH_GAP && gap_reg == '0)
            resolved = PH_PRE_LOW;
        if (resolved == PH_PRE_LOW && pre_low_reg == '0)
            resolved = PH_TRIGGER;
        if (go)
        begin
            count_next = '0;
            phase_next = resolved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PRE_LOW;
            count_reg      <= '0;
            echo_count_reg <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            echo_count_reg <= echo_count_next;
        end
    end

    // ---------------- distance and smoothing ----------------
    assign product = PROD_W'(echo_count_reg) * PROD_W'(DIST_SCALE) + PROD_W'(DIST_ROUND);

    // divisions by constants as multiply by rounded-up reciprocal and shift
    assign raw_mul    = RAW_MUL_W'(prod_reg) * RAW_MUL_W'(DIST_RECIP);
    assign smooth_mul = SMOOTH_MUL_W'(sum_reg) * SMOOTH_MUL_W'(SMOOTH_RECIP);

    assign raw_sat = (|raw_q_reg[RAW_Q_W-1:DIST_W]) ? {DIST_W{1'b1}} : raw_q_reg[DIST_W-1:0];
    assign smooth_sum = {2'b00, smoothed_reg, 1'b0} + {2'b00, raw_sat, 1'b0}
                      + {3'b000, raw_sat} + SMOOTH_SUM_W'(2);

    always_ff @(posedge clk)
    begin
        if (cmd.load_raw)
            prod_reg <= product;
        if (cmd.div_raw)
            raw_q_reg <= raw_mul[RAW_MUL_W-1:DIST_SHIFT];
        if (cmd.save_raw)
            sum_reg <= smooth_sum;
        if (cmd.div_smooth)
            smooth_q_reg <= smooth_mul[SMOOTH_SHIFT+DIST_W-1:SMOOTH_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= DIST_W'(SMOOTH_RESET);
            last_raw_reg <= '0;
        end
        else
        begin
            if (cmd.save_raw)
                last_raw_reg <= raw_sat;
            if (cmd.finish)
                smoothed_reg <= smooth_q_reg;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.step && !tick_completes)
        begin
            trig_out_reg <= tick_trig;
            filt_out_reg <= smoothed_reg;
            raw_out_reg  <= last_raw_reg;
            done_out_reg <= 1'b0;
            tout_out_reg <= tick_tout;
        end
        else if (cmd.finish)
        begin
            trig_out_reg <= 1'b0;
            filt_out_reg <= smooth_q_reg;
            raw_out_reg  <= last_raw_reg;
            done_out_reg <= 1'b1;
            tout_out_reg <= 1'b0;
        end
    end

    assign trigger_level     = trig_out_reg;
    assign filtered_distance = filt_out_reg;
    assign raw_distance      = raw_out_reg;
    assign measure_done      = done_out_reg;
    assign timed_out         = tout_out_reg;

    assign status.completes = tick_completes;

endmodule

`default_nettype wire

FILE: hdl/ultrasonic_echo_ranger_filtered_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_filtered_unit
// Ranging sequencer with echo timing, distance scaling and smoothing.
// ----------------------------------------------------------------------------
// results: a tick shows its result in the cycle after it is accepted, and one
//   tick is taken every cycle while idle and the result side keeps up
// a tick that ends an echo holds off the next tick until its result shows,
//   after the product, distance reciprocal multiply, sum and smoothing
//   reciprocal multiply registers and once the result side is free
// reset: trigger sequence restarts in pre-low, registers take their defaults,
//   filtered distance starts at 50 cm
`default_nettype none

module ultrasonic_echo_ranger_filtered_unit #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    uer_tick_if.sink                             tick,
    uer_result_if.source                         result
);
    import uer_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    uer_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .echo_level        (tick.echo_level),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .trigger_level     (result.trigger_level),
        .filtered_distance (result.filtered_distance),
        .raw_distance      (result.raw_distance),
        .measure_done      (result.measure_done),
        .timed_out         (result.timed_out)
    );

    assign tick.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

`default_nettype wire
